[hw/rtl/csrs_pkg.sv]
// Shared constants, register codes and control structs of the span read splitter.
`timescale 1ns / 1ps

package csrs_pkg;

	// Segment configuration.
	localparam int MAX_SEGMENTS = 4;
	localparam int SEG_IDX_W    = 2;
	localparam int SEG_CNT_W    = 3;

	// Field widths.
	localparam int OFFSET_W = 48;
	localparam int COUNT_W  = 32;
	localparam int END_W    = OFFSET_W + 1;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SEG_COUNT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEG_SIZE_0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEG_SIZE_1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SEG_SIZE_2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SEG_SIZE_3 = 3'd4;

	// Result status codes.
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic walk;
		logic prep;
		logic skip;
		logic emit_err;
		logic emit_empty;
		logic emit_piece;
	} csrs_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic found;
		logic fits;
		logic seg_last;
		logic size_zero;
		logic piece_last;
		logic count_zero;
		logic out_free;
	} csrs_stat_t;

endpackage

[hw/rtl/csrs_regs.sv]
// Configuration registers: segment count and segment sizes, with a size read port.
`timescale 1ns / 1ps

module csrs_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [csrs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [csrs_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [csrs_pkg::SEG_IDX_W-1:0]    rd_index,
	output logic [csrs_pkg::OFFSET_W-1:0]     rd_size,
	output logic [csrs_pkg::SEG_CNT_W-1:0]    seg_used
);
	import csrs_pkg::*;

	logic [SEG_CNT_W-1:0] seg_count_q;
	logic [OFFSET_W-1:0]  seg_size_q [MAX_SEGMENTS];
	logic [CFG_IDX_W-1:0] size_sel;

	// The port takes a write in every cycle.
	assign cfg_ready = 1'b1;
	assign size_sel  = cfg_index - REG_SEG_SIZE_0;

	// Register writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_count_q <= SEG_CNT_W'(1);
			for (int i = 0; i < MAX_SEGMENTS; i++) begin
				seg_size_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index) inside
				REG_SEG_COUNT: begin
					seg_count_q <= cfg_data[SEG_CNT_W-1:0];
				end
				REG_SEG_SIZE_0, REG_SEG_SIZE_1, REG_SEG_SIZE_2, REG_SEG_SIZE_3: begin
					seg_size_q[size_sel[SEG_IDX_W-1:0]] <= cfg_data[OFFSET_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Segments in use: zero counts as one, large values saturate.
	always_comb begin
		if (seg_count_q == '0) begin
			seg_used = SEG_CNT_W'(1);
		end else if (seg_count_q > SEG_CNT_W'(MAX_SEGMENTS)) begin
			seg_used = SEG_CNT_W'(MAX_SEGMENTS);
		end else begin
			seg_used = seg_count_q;
		end
	end

	assign rd_size = seg_size_q[rd_index];

endmodule

[hw/rtl/csrs_dp.sv]
// Datapath: segment walk, range check, piece arithmetic and the result register.
`timescale 1ns / 1ps

module csrs_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  csrs_pkg::csrs_cmd_t               cmd,
	output csrs_pkg::csrs_stat_t              stat,
	input  logic [csrs_pkg::OFFSET_W-1:0]     start_offset,
	input  logic [csrs_pkg::COUNT_W-1:0]      byte_count,
	input  logic [csrs_pkg::OFFSET_W-1:0]     rd_size,
	input  logic [csrs_pkg::SEG_CNT_W-1:0]    seg_used,
	output logic [csrs_pkg::SEG_IDX_W-1:0]    rd_index,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              status,
	output logic [csrs_pkg::SEG_IDX_W-1:0]    segment_index,
	output logic [csrs_pkg::OFFSET_W-1:0]     segment_offset,
	output logic [csrs_pkg::COUNT_W-1:0]      piece_length,
	output logic                              last_piece
);
	import csrs_pkg::*;

	logic [OFFSET_W-1:0]  off_q;
	logic [END_W-1:0]     end_q;
	logic [COUNT_W-1:0]   count_q;
	logic [SEG_IDX_W-1:0] seg_q;
	logic [SEG_IDX_W-1:0] first_seg_q;
	logic                 found_q;
	logic                 fits_q;

	logic                 out_valid_q;
	logic                 status_q;
	logic [SEG_IDX_W-1:0] segment_index_q;
	logic [OFFSET_W-1:0]  segment_offset_q;
	logic [COUNT_W-1:0]   piece_length_q;
	logic                 last_piece_q;

	logic                 off_in_seg;
	logic                 end_in_seg;
	logic [OFFSET_W-1:0]  avail;
	logic                 piece_last;
	logic [COUNT_W-1:0]   piece_len;

	// Walk compares and piece length for the segment under seg_q.
	assign off_in_seg = off_q < rd_size;
	assign end_in_seg = end_q <= {1'b0, rd_size};
	assign avail      = rd_size - off_q;
	assign piece_last = {{(OFFSET_W-COUNT_W){1'b0}}, count_q} <= avail;
	assign piece_len  = piece_last ? count_q : avail[COUNT_W-1:0];

	assign rd_index        = seg_q;
	assign stat.found      = found_q;
	assign stat.fits       = fits_q;
	assign stat.seg_last   = {1'b0, seg_q} == (seg_used - SEG_CNT_W'(1));
	assign stat.size_zero  = rd_size == '0;
	assign stat.piece_last = piece_last;
	assign stat.count_zero = count_q == '0;
	assign stat.out_free   = !out_valid_q || !out_stall;

	// Request state: offset and end position walked down segment by segment.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			off_q       <= start_offset;
			end_q       <= {1'b0, start_offset} + {{(END_W-COUNT_W){1'b0}}, byte_count};
			count_q     <= byte_count;
			seg_q       <= '0;
			first_seg_q <= '0;
			found_q     <= 1'b0;
			fits_q      <= 1'b0;
		end else if (cmd.walk) begin
			if (!found_q) begin
				if (off_in_seg) begin
					found_q     <= 1'b1;
					first_seg_q <= seg_q;
				end else begin
					off_q <= off_q - rd_size;
				end
			end
			if (!fits_q) begin
				if (end_in_seg) begin
					fits_q <= 1'b1;
				end else begin
					end_q <= end_q - {1'b0, rd_size};
				end
			end
			seg_q <= seg_q + SEG_IDX_W'(1);
		end else if (cmd.prep) begin
			seg_q <= first_seg_q;
		end else if (cmd.skip) begin
			seg_q <= seg_q + SEG_IDX_W'(1);
		end else if (cmd.emit_piece) begin
			count_q <= count_q - piece_len;
			off_q   <= '0;
			seg_q   <= seg_q + SEG_IDX_W'(1);
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_err || cmd.emit_empty || cmd.emit_piece) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (cmd.emit_err) begin
			status_q         <= STATUS_RANGE;
			segment_index_q  <= '0;
			segment_offset_q <= '0;
			piece_length_q   <= '0;
			last_piece_q     <= 1'b1;
		end else if (cmd.emit_empty) begin
			status_q         <= STATUS_OK;
			segment_index_q  <= first_seg_q;
			segment_offset_q <= off_q;
			piece_length_q   <= '0;
			last_piece_q     <= 1'b1;
		end else if (cmd.emit_piece) begin
			status_q         <= STATUS_OK;
			segment_index_q  <= seg_q;
			segment_offset_q <= off_q;
			piece_length_q   <= piece_len;
			last_piece_q     <= piece_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign segment_index  = segment_index_q;
	assign segment_offset = segment_offset_q;
	assign piece_length   = piece_length_q;
	assign last_piece     = last_piece_q;

	// At most one result is written per cycle.
	a_one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.emit_err, cmd.emit_empty, cmd.emit_piece}))
		else $error("more than one result written in a cycle");

	// A result is written only when the result register can take it.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_err || cmd.emit_empty || cmd.emit_piece) |-> stat.out_free)
		else $error("result register overwritten");

	// Zero-size segments never yield a piece.
	a_no_empty_seg: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_piece |-> !stat.size_zero && !stat.count_zero)
		else $error("piece issued from an empty segment");

	// An error result is always a single, empty, final one.
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_err |=> out_valid_q && last_piece_q && piece_length_q == '0)
		else $error("malformed error result");

endmodule

[hw/rtl/csrs_ctrl.sv]
// Controller: sequences accept, segment walk, range decision and piece issue.
`timescale 1ns / 1ps

module csrs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  csrs_pkg::csrs_stat_t stat,
	output csrs_pkg::csrs_cmd_t  cmd
);
	import csrs_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DECIDE,
		ST_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_stall = state_q != ST_IDLE;

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_WALK;
				end
			end
			ST_WALK: begin
				if (stat.found && stat.fits) begin
					state_d = ST_DECIDE;
				end else begin
					cmd.walk = 1'b1;
					if (stat.seg_last) begin
						state_d = ST_DECIDE;
					end
				end
			end
			ST_DECIDE: begin
				if (!(stat.found && stat.fits)) begin
					if (stat.out_free) begin
						cmd.emit_err = 1'b1;
						state_d      = ST_IDLE;
					end
				end else if (stat.count_zero) begin
					if (stat.out_free) begin
						cmd.emit_empty = 1'b1;
						state_d        = ST_IDLE;
					end
				end else begin
					cmd.prep = 1'b1;
					state_d  = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (stat.size_zero) begin
					cmd.skip = 1'b1;
				end else if (stat.out_free) begin
					cmd.emit_piece = 1'b1;
					if (stat.piece_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[hw/rtl/concat_span_read_splitter.sv]
// Top level of the concatenated-volume read splitter.
`timescale 1ns / 1ps

// A read request (start_offset, byte_count) on a volume of up to four segments
// laid end to end is transferred in once in_stall is low, checked against the
// volume length and split into one result per non-empty segment it touches,
// the final one marked by last_piece. A request that starts at or beyond the
// end of the volume, or runs past it, yields a single result with status 1;
// a zero-length request inside the volume yields one empty piece. One request
// is in work at a time. From its transfer in until its last result enters the
// output register, it goes through a segment walk, a decision and, when it is
// in range and not empty, the issue of its pieces. The walk visits segments
// in order, one size compare and subtract per cycle, at most the segments in
// use, and ends once it has located both the start and the end of the request
// or has visited the last segment in use. The decision writes any error or
// empty result. The issue steps over zero-size segments and writes one piece
// for each non-empty segment; every result write waits while out_stall holds
// a result in the output register. The next request
// is taken in the cycle after the last result enters the output register,
// even while that result still waits there. Configuration writes are accepted
// in every cycle and must be made while no request is in work.
module concat_span_read_splitter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [csrs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [csrs_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [csrs_pkg::OFFSET_W-1:0]     start_offset,
	input  logic [csrs_pkg::COUNT_W-1:0]      byte_count,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              status,
	output logic [csrs_pkg::SEG_IDX_W-1:0]    segment_index,
	output logic [csrs_pkg::OFFSET_W-1:0]     segment_offset,
	output logic [csrs_pkg::COUNT_W-1:0]      piece_length,
	output logic                              last_piece
);
	import csrs_pkg::*;

	csrs_cmd_t            cmd;
	csrs_stat_t           stat;
	logic [SEG_IDX_W-1:0] rd_index;
	logic [OFFSET_W-1:0]  rd_size;
	logic [SEG_CNT_W-1:0] seg_used;

	// Configuration registers.
	csrs_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rd_index  (rd_index),
		.rd_size   (rd_size),
		.seg_used  (seg_used)
	);

	// Sequencer.
	csrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Address arithmetic and result register.
	csrs_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.start_offset   (start_offset),
		.byte_count     (byte_count),
		.rd_size        (rd_size),
		.seg_used       (seg_used),
		.rd_index       (rd_index),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.segment_index  (segment_index),
		.segment_offset (segment_offset),
		.piece_length   (piece_length),
		.last_piece     (last_piece)
	);

endmodule
